// ----- src/kcrt_pkg.sv -----
package kcrt_pkg;

  localparam int Capacity = 32;
  localparam int KeyBits  = 8;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    CMD_SCHED  = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_RETAIN = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOROOM  = 2'd2,
    ST_BADIDX  = 2'd3
  } status_t;

  // one stored entry: present bit, handle, sequence, key, countdown
  typedef struct packed {
    logic                present;
    logic [15:0]         ref_h;
    logic [31:0]         seq;
    logic [KeyBits-1:0]  key;
    logic [15:0]         cd;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KRD,
    S_KWR,
    S_KDONE,
    S_ERD,
    S_EOUT,
    S_MRD,
    S_MWR,
    S_OUT,
    S_WAIT
  } state_t;

  // result word as carried to the output register
  typedef struct packed {
    logic            last;
    logic [CntW-1:0] tcount;
    logic [4:0]      idx;
    logic [31:0]     seq;
    logic            present;
    logic [15:0]     ref_h;
    logic            valid;
    logic [1:0]      status;
  } result_t;

endpackage

// ----- src/kcrt_store.sv -----
module kcrt_store (
  input  logic                    clk,
  input  logic                    we,
  input  logic [kcrt_pkg::IdxW-1:0] waddr,
  input  kcrt_pkg::entry_t        wdata,
  input  logic [kcrt_pkg::IdxW-1:0] raddr,
  output kcrt_pkg::entry_t        rdata
);
  import kcrt_pkg::*;

  entry_t mem [Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/keyed_countdown_release_table.sv -----
// Schedule, clear, rejected retain and a retain that keeps nothing give the result
// word in the cycle after accept. A key event walks the table (read, then write
// per entry), then sends each released word (ready store read, then output).
// Retain merge: a read state and a write state per entry moved (kept ready plus shifted table).
// One command at a time; in_tready is low from accept until its last word is taken.
// Reset (rst_n low, synchronous) empties both stores and the output register.
module keyed_countdown_release_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[1:0], order_ref[17:2], order_present[18], seq_number[50:19],
  // key_id[58:51], countdown[74:59], first_kept[80:75], zeros up to 87
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], item_valid[2], released_ref[18:3], released_present[19],
  // released_seq[51:20], released_index[56:52], table_count[62:57], zero [63]
  output logic [63:0] out_tdata,
  output logic        out_tlast
);
  import kcrt_pkg::*;

  logic [1:0]  in_cmd;
  logic [15:0] in_ref;
  logic        in_pres;
  logic [31:0] in_seq;
  logic [7:0]  in_key;
  logic [15:0] in_cd;
  logic [5:0]  in_first;
  assign in_cmd   = in_tdata[1:0];
  assign in_ref   = in_tdata[17:2];
  assign in_pres  = in_tdata[18];
  assign in_seq   = in_tdata[50:19];
  assign in_key   = in_tdata[58:51];
  assign in_cd    = in_tdata[74:59];
  assign in_first = in_tdata[80:75];

  state_t state_r, state_nxt;
  logic [CntW-1:0] tsize_r, tsize_nxt, rsize_r, rsize_nxt;
  logic [CntW-1:0] rd_r, rd_nxt, keep_r, keep_nxt, first_r, first_nxt;
  logic [CntW-1:0] left_r, left_nxt, right_r, right_nxt, dst_r, dst_nxt;
  logic [KeyBits-1:0] key_r, key_nxt;
  result_t res_r, res_nxt;
  logic    ovalid_r, ovalid_nxt;

  logic t_we, r_we;
  logic [IdxW-1:0] t_wa, t_ra, r_wa, r_ra;
  entry_t t_wd, r_wd, t_rd, r_rd;

  kcrt_store u_tab (.clk, .we(t_we), .waddr(t_wa), .wdata(t_wd),
                    .raddr(t_ra), .rdata(t_rd));
  kcrt_store u_rdy (.clk, .we(r_we), .waddr(r_wa), .wdata(r_wd),
                    .raddr(r_ra), .rdata(r_rd));

  logic match, due;
  logic take_tab;
  logic [CntW-1:0] remaining;
  assign match = t_rd.present && (t_rd.key == key_r);
  assign due   = match && (t_rd.cd <= 16'd1) && (rsize_r < CntW'(Capacity));
  // merge takes table side when it has entries left and its seq is strictly larger
  assign take_tab = (left_r != '0) && (t_rd.seq > r_rd.seq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tsize_r <= '0;
      rsize_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tsize_r <= tsize_nxt;
      rsize_r <= rsize_nxt;
      ovalid_r <= ovalid_nxt;
    end
    rd_r <= rd_nxt; keep_r <= keep_nxt; first_r <= first_nxt;
    left_r <= left_nxt; right_r <= right_nxt; dst_r <= dst_nxt;
    key_r <= key_nxt; res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r; tsize_nxt = tsize_r; rsize_nxt = rsize_r;
    rd_nxt = rd_r; keep_nxt = keep_r; first_nxt = first_r;
    left_nxt = left_r; right_nxt = right_r; dst_nxt = dst_r;
    key_nxt = key_r; res_nxt = res_r;
    ovalid_nxt = ovalid_r;
    t_we = 1'b0; r_we = 1'b0;
    t_wa = '0; r_wa = '0; t_wd = t_rd; r_wd = t_rd;
    t_ra = rd_r[IdxW-1:0]; r_ra = '0;
    remaining = '0;
    in_tready = 1'b0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          res_nxt = '0;
          res_nxt.last = 1'b1;
          key_nxt = in_key[KeyBits-1:0];
          state_nxt = S_OUT;
          case (cmd_t'(in_cmd))
            CMD_SCHED: begin
              if (tsize_r >= CntW'(Capacity)) begin
                res_nxt.status = ST_FULL;
              end else begin
                t_we = 1'b1;
                t_wa = tsize_r[IdxW-1:0];
                t_wd = '{present: in_pres, ref_h: in_ref, seq: in_seq,
                         key: in_key[KeyBits-1:0], cd: in_cd};
                tsize_nxt = tsize_r + 1'b1;
              end
              res_nxt.tcount = tsize_nxt;
            end
            CMD_KEY: begin
              rd_nxt = '0; keep_nxt = '0;
              // released entries land in the ready store from here on
              first_nxt = rsize_r;
              state_nxt = S_KRD;
            end
            CMD_RETAIN: begin
              remaining = rsize_r - in_first;
              res_nxt.tcount = tsize_r;
              if (in_first > rsize_r) begin
                res_nxt.status = ST_BADIDX;
              end else if (remaining == '0) begin
                rsize_nxt = '0;
              end else if (remaining > CntW'(Capacity) - tsize_r) begin
                res_nxt.status = ST_NOROOM;
              end else begin
                first_nxt = in_first;
                left_nxt = tsize_r; right_nxt = rsize_r;
                dst_nxt = tsize_r + remaining;
                state_nxt = S_MRD;
              end
            end
            default: begin
              tsize_nxt = '0; rsize_nxt = '0;
            end
          endcase
          if (state_nxt == S_OUT) ovalid_nxt = 1'b1;
        end
      end
      S_KRD: begin
        // issue read of rd_r
        if (rd_r >= tsize_r) state_nxt = S_KDONE;
        else state_nxt = S_KWR;
      end
      S_KWR: begin
        if (due) begin
          r_we = 1'b1; r_wa = rsize_r[IdxW-1:0]; r_wd = t_rd;
          rsize_nxt = rsize_r + 1'b1;
        end else begin
          t_we = 1'b1; t_wa = keep_r[IdxW-1:0]; t_wd = t_rd;
          if (match && t_rd.cd > 16'd1) t_wd.cd = t_rd.cd - 16'd1;
          keep_nxt = keep_r + 1'b1;
        end
        rd_nxt = rd_r + 1'b1;
        state_nxt = S_KRD;
      end
      S_KDONE: begin
        tsize_nxt = keep_r;
        if (rsize_r == first_r) begin
          res_nxt = '0;
          res_nxt.tcount = keep_r;
          res_nxt.last = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          right_nxt = first_r;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        r_ra = right_r[IdxW-1:0];
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        // keep the address so the read data holds while the output stalls
        r_ra = right_r[IdxW-1:0];
        if (!ovalid_r || out_tready) begin
          res_nxt = '0;
          res_nxt.valid = 1'b1;
          res_nxt.ref_h = r_rd.ref_h;
          res_nxt.present = r_rd.present;
          res_nxt.seq = r_rd.seq;
          res_nxt.idx = right_r[IdxW-1:0];
          res_nxt.tcount = tsize_r;
          res_nxt.last = ((right_r + 1'b1) == rsize_r);
          ovalid_nxt = 1'b1;
          right_nxt = right_r + 1'b1;
          state_nxt = res_nxt.last ? S_WAIT : S_ERD;
        end
      end
      S_MRD: begin
        t_ra = IdxW'(left_r - 1'b1);
        r_ra = IdxW'(right_r - 1'b1);
        if (right_r == first_r) begin
          tsize_nxt = tsize_r + (rsize_r - first_r);
          rsize_nxt = '0;
          res_nxt.tcount = tsize_nxt;
          ovalid_nxt = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        t_we = 1'b1; t_wa = IdxW'(dst_r - 1'b1);
        dst_nxt = dst_r - 1'b1;
        if (take_tab) begin
          t_wd = t_rd; left_nxt = left_r - 1'b1;
        end else begin
          t_wd = r_rd; right_nxt = right_r - 1'b1;
        end
        state_nxt = S_MRD;
      end
      S_OUT: begin
        state_nxt = S_WAIT;
      end
      default: begin
        if (!ovalid_r || out_tready) begin
          if (!ovalid_nxt) state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // single result word register
  assign out_tvalid = ovalid_r;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {1'b0, res_r.tcount, res_r.idx, res_r.seq, res_r.present,
                       res_r.ref_h, res_r.valid, res_r.status};

  // Released words are read back from the ready store after the walk, so
  // each carries the final table count.
  property p_ready_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> !in_tready;
  endproperty
  assert property (p_ready_busy) else $error("ready while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    tsize_r <= CntW'(Capacity)) else $error("table size overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    rsize_r <= CntW'(Capacity)) else $error("ready size overflow");

endmodule
